/* sv/material_sort_sequencer_macros.svh */
// Assertion macros for the material sort sequencer.
// Included by the top level; defining NO_ASSERTIONS turns every check into nothing.
`ifndef MATERIAL_SORT_SEQUENCER_MACROS_SVH
`define MATERIAL_SORT_SEQUENCER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mss: same-cycle check failed");
`define MSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mss: next-cycle check failed");
`else
`define MSS_ASSERT_SAME(label, clk, rst, ante, cons)
`define MSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/mss_pkg.sv */
// Shared types and constants of the material sort sequencer.
// Used by mss_ctrl, mss_datapath, material_sort_sequencer and tb; depends on nothing.
package mss_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   localparam int SAMPLE_W = 10;
   localparam int STEP_W   = 8;
   localparam int TALLY_W  = 8;
   localparam int CSR_W    = 10;
   localparam int CSR_IDX_W = 3;

   localparam logic [SAMPLE_W-1:0] MIN_INIT   = 10'd1023;
   localparam logic [TALLY_W-1:0]  TALLY_MAX  = 8'd255;

   localparam logic [SAMPLE_W-1:0] BLACK_RESET   = 10'd974;
   localparam logic [SAMPLE_W-1:0] WHITE_RESET   = 10'd850;
   localparam logic [SAMPLE_W-1:0] STEEL_RESET   = 10'd380;
   localparam logic [STEP_W-1:0]   QUARTER_RESET = 8'd50;
   localparam logic [STEP_W-1:0]   HALF_RESET    = 8'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_BLACK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WHITE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEEL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUARTER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF    = 3'd4;

   localparam logic [1:0] REQ_OPTICAL = 2'd0;
   localparam logic [1:0] REQ_SAMPLE  = 2'd1;
   localparam logic [1:0] REQ_EXIT    = 2'd2;

   localparam logic [1:0] CLASS_BLACK    = 2'd0;
   localparam logic [1:0] CLASS_STEEL    = 2'd1;
   localparam logic [1:0] CLASS_WHITE    = 2'd2;
   localparam logic [1:0] CLASS_ALUMINUM = 2'd3;

   localparam logic [1:0] TURN_NONE    = 2'd0;
   localparam logic [1:0] TURN_QUARTER = 2'd1;
   localparam logic [1:0] TURN_HALF    = 2'd2;
   localparam logic [1:0] TURN_BACK    = 2'd3;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [SAMPLE_W-1:0] sample;
   } req_item_type;

   typedef struct packed {
      logic               move_valid;
      logic               move_dir;
      logic [STEP_W-1:0]  move_steps;
      logic [1:0]         target_bin;
      logic               part_enqueued;
      logic [1:0]         part_class;
      logic               queue_overflow;
      logic [LEVEL_W-1:0] queue_level;
      logic [TALLY_W-1:0] bin_tally;
   } rsp_item_type;

   typedef struct packed {
      logic capture;
      logic act;
      logic finish;
   } cmd_type;

endpackage

/* sv/mss_ctrl.sv */
// Controller of the material sort sequencer: steps each transaction through
// capture, action and dequeue. Depends on mss_pkg.
module mss_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output mss_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ACT  = 2'd1;
   localparam logic [1:0] ST_POP  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_ACT;
         end
         ST_ACT:  state_in = ST_POP;
         ST_POP:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign cmd.capture = start && (state_ff == ST_IDLE);
   assign cmd.act     = (state_ff == ST_ACT);
   assign cmd.finish  = (state_ff == ST_POP);

endmodule

/* sv/mss_datapath.sv */
// Datapath of the material sort sequencer: configuration registers, window and
// minimum tracking, class queue, tray position and bin counters. Depends on mss_pkg.
module mss_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  mss_pkg::cmd_type                 cmd,
   input  mss_pkg::req_item_type            req_data,
   input  logic                             csr_we,
   input  logic [mss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mss_pkg::CSR_W-1:0]        csr_wdata,
   output logic                             rsp_strobe,
   output mss_pkg::rsp_item_type            rsp_data
);

   logic [mss_pkg::SAMPLE_W-1:0] black_ff, white_ff, steel_ff;
   logic [mss_pkg::STEP_W-1:0]   quarter_ff, half_ff;

   mss_pkg::req_item_type req_ff;

   logic                         window_ff, window_in;
   logic                         pending_ff, pending_in;
   logic [mss_pkg::SAMPLE_W-1:0] min_ff, min_in;
   logic                         exit_half_ff, exit_half_in;
   logic                         outstanding_ff, outstanding_in;
   logic [1:0]                   tray_ff, tray_in;
   logic [mss_pkg::PTR_W-1:0]    head_ff, head_in;
   logic [mss_pkg::PTR_W-1:0]    tail_ff, tail_in;
   logic [mss_pkg::LEVEL_W-1:0]  count_ff, count_in;
   logic [mss_pkg::TALLY_W-1:0]  bin_ff [4];
   logic [mss_pkg::TALLY_W-1:0]  bin_in;
   logic                         bin_we;
   logic [1:0]                   queue_ff [mss_pkg::QUEUE_DEPTH];
   logic                         queue_we;

   logic                         enq_ff, enq_in;
   logic [1:0]                   cls_ff, cls_in;
   logic                         ovf_ff, ovf_in;
   logic [mss_pkg::TALLY_W-1:0]  tally_ff, tally_in;

   mss_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                  strobe_ff;

   logic [mss_pkg::SAMPLE_W-1:0] new_min;
   logic [1:0]                   new_cls;
   logic [1:0]                   pop_bin;
   logic [1:0]                   diff;
   logic                         pop_go;

   assign new_min = (req_ff.sample < min_ff) ? req_ff.sample : min_ff;

   always_comb begin
      priority if (new_min > black_ff) begin
         new_cls = mss_pkg::CLASS_BLACK;
      end else if (new_min > white_ff) begin
         new_cls = mss_pkg::CLASS_WHITE;
      end else if (new_min > steel_ff) begin
         new_cls = mss_pkg::CLASS_STEEL;
      end else begin
         new_cls = mss_pkg::CLASS_ALUMINUM;
      end
   end

   // Action phase: the transaction's own effect on window, queue and bins.
   always_comb begin
      window_in    = window_ff;
      pending_in   = pending_ff;
      min_in       = min_ff;
      exit_half_in = exit_half_ff;
      tail_in      = tail_ff;
      enq_in       = 1'b0;
      cls_in       = 2'b00;
      ovf_in       = 1'b0;
      tally_in     = '0;
      queue_we     = 1'b0;
      bin_we       = 1'b0;
      bin_in       = (bin_ff[tray_ff] == mss_pkg::TALLY_MAX) ? bin_ff[tray_ff]
                                                             : bin_ff[tray_ff] + 1'b1;
      unique case (req_ff.req_type)
         mss_pkg::REQ_OPTICAL: begin
            if (!window_ff) begin
               window_in  = 1'b1;
               pending_in = 1'b1;
               min_in     = mss_pkg::MIN_INIT;
            end else begin
               window_in = 1'b0;
            end
         end
         mss_pkg::REQ_SAMPLE: begin
            if (window_ff || pending_ff) begin
               min_in = new_min;
               if (!window_ff) begin
                  pending_in = 1'b0;
                  cls_in     = new_cls;
                  if (count_ff == mss_pkg::LEVEL_W'(mss_pkg::QUEUE_DEPTH)) begin
                     ovf_in = 1'b1;
                  end else begin
                     queue_we = 1'b1;
                     enq_in   = 1'b1;
                     tail_in  = (tail_ff == mss_pkg::PTR_W'(mss_pkg::QUEUE_DEPTH - 1))
                                ? '0 : tail_ff + 1'b1;
                  end
               end
            end
         end
         mss_pkg::REQ_EXIT: begin
            exit_half_in = !exit_half_ff;
            if (exit_half_ff) begin
               bin_we   = 1'b1;
               tally_in = bin_in;
            end
         end
         default: begin
         end
      endcase
   end

   // Dequeue phase: pop one part when the tray is free and build the result.
   assign pop_go  = !outstanding_ff && (count_ff != '0);
   assign pop_bin = queue_ff[head_ff];
   assign diff    = 2'(pop_bin - tray_ff);

   always_comb begin
      head_in        = head_ff;
      tray_in        = tray_ff;
      outstanding_in = outstanding_ff;
      rsp_in         = '0;
      if (cmd.act) begin
         if (queue_we) begin
            count_in = count_ff + 1'b1;
         end else begin
            count_in = count_ff;
         end
         if (bin_we) outstanding_in = 1'b0;
      end else begin
         count_in = count_ff;
      end
      if (pop_go) begin
         head_in = (head_ff == mss_pkg::PTR_W'(mss_pkg::QUEUE_DEPTH - 1))
                   ? '0 : head_ff + 1'b1;
         tray_in = pop_bin;
         if (cmd.finish) begin
            count_in       = count_ff - 1'b1;
            outstanding_in = 1'b1;
         end
         rsp_in.move_valid = 1'b1;
         rsp_in.target_bin = pop_bin;
         unique case (diff)
            mss_pkg::TURN_QUARTER: begin
               rsp_in.move_dir   = 1'b1;
               rsp_in.move_steps = quarter_ff;
            end
            mss_pkg::TURN_HALF: begin
               rsp_in.move_dir   = 1'b1;
               rsp_in.move_steps = half_ff;
            end
            mss_pkg::TURN_BACK: begin
               rsp_in.move_dir   = 1'b0;
               rsp_in.move_steps = quarter_ff;
            end
            mss_pkg::TURN_NONE: begin
               rsp_in.move_dir   = 1'b0;
               rsp_in.move_steps = '0;
            end
            default: begin
            end
         endcase
         rsp_in.queue_level = count_ff - 1'b1;
      end else begin
         rsp_in.queue_level = count_ff;
      end
      rsp_in.part_enqueued  = enq_ff;
      rsp_in.part_class     = cls_ff;
      rsp_in.queue_overflow = ovf_ff;
      rsp_in.bin_tally      = tally_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         black_ff   <= mss_pkg::BLACK_RESET;
         white_ff   <= mss_pkg::WHITE_RESET;
         steel_ff   <= mss_pkg::STEEL_RESET;
         quarter_ff <= mss_pkg::QUARTER_RESET;
         half_ff    <= mss_pkg::HALF_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mss_pkg::CSR_BLACK:   black_ff   <= csr_wdata[mss_pkg::SAMPLE_W-1:0];
            mss_pkg::CSR_WHITE:   white_ff   <= csr_wdata[mss_pkg::SAMPLE_W-1:0];
            mss_pkg::CSR_STEEL:   steel_ff   <= csr_wdata[mss_pkg::SAMPLE_W-1:0];
            mss_pkg::CSR_QUARTER: quarter_ff <= csr_wdata[mss_pkg::STEP_W-1:0];
            mss_pkg::CSR_HALF:    half_ff    <= csr_wdata[mss_pkg::STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= 1'b0;
         pending_ff     <= 1'b0;
         min_ff         <= mss_pkg::MIN_INIT;
         exit_half_ff   <= 1'b0;
         outstanding_ff <= 1'b0;
         tray_ff        <= 2'b00;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         bin_ff         <= '{default: '0};
         strobe_ff      <= 1'b0;
      end else begin
         strobe_ff <= cmd.finish;
         if (cmd.act) begin
            window_ff      <= window_in;
            pending_ff     <= pending_in;
            min_ff         <= min_in;
            exit_half_ff   <= exit_half_in;
            tail_ff        <= tail_in;
            count_ff       <= count_in;
            outstanding_ff <= outstanding_in;
            if (bin_we) bin_ff[tray_ff] <= bin_in;
         end
         if (cmd.finish) begin
            head_ff        <= head_in;
            tray_ff        <= tray_in;
            count_ff       <= count_in;
            outstanding_ff <= outstanding_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.act) begin
         enq_ff   <= enq_in;
         cls_ff   <= cls_in;
         ovf_ff   <= ovf_in;
         tally_ff <= tally_in;
         if (queue_we) queue_ff[tail_ff] <= new_cls;
      end
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* sv/material_sort_sequencer.sv */
// Top level of the material sort sequencer: joins the controller and datapath.
// Depends on mss_pkg, mss_ctrl, mss_datapath and material_sort_sequencer_macros.svh.
//
// Channel     Ports                                Transfer
// request     start, busy, req_data                start high while busy low
// response    rsp_strobe, rsp_data                 one cycle per result, no stall
// config      csr_we, csr_index, csr_wdata         csr_we high, written at once
//
// Each transaction steps through capture, action and dequeue in the controller
// sequence; a new start is taken in the cycle the result is shown.
// Reset is synchronous and restores configuration, state and counters, but not the
// request, result or queue registers; only queue entries written since reset are read.
// The response side cannot stall, so every result is shown exactly once.
`include "material_sort_sequencer_macros.svh"

module material_sort_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  mss_pkg::req_item_type         req_data,
   output logic                          rsp_strobe,
   output mss_pkg::rsp_item_type         rsp_data,
   input  logic                          csr_we,
   input  logic [mss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mss_pkg::CSR_W-1:0]     csr_wdata
);

   mss_pkg::cmd_type cmd;

   mss_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   mss_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   `MSS_ASSERT_SAME(a_strobe_when_idle, clock, reset, rsp_strobe, !busy)
   `MSS_ASSERT_NEXT(a_start_sets_busy, clock, reset, start && !busy, busy)
   `MSS_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)
   `MSS_ASSERT_SAME(a_no_move_quiet, clock, reset, rsp_strobe && !rsp_data.move_valid, (rsp_data.move_steps == '0) && (rsp_data.target_bin == '0) && !rsp_data.move_dir)

endmodule

/* tb/tb.sv */
// Self-checking testbench for material_sort_sequencer: directed and random transactions.
// Depends on mss_pkg and the material_sort_sequencer RTL; results are predicted in place.
module tb;
   import mss_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PRINT_LIMIT = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_item_type req_data = '0;
   logic rsp_strobe;
   rsp_item_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   material_sort_sequencer dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Sorter state as the block should hold it.
   logic [SAMPLE_W-1:0] black_thr = BLACK_RESET;
   logic [SAMPLE_W-1:0] white_thr = WHITE_RESET;
   logic [SAMPLE_W-1:0] steel_thr = STEEL_RESET;
   logic [STEP_W-1:0] quarter_cnt = QUARTER_RESET;
   logic [STEP_W-1:0] half_cnt = HALF_RESET;
   logic win_open = 1'b0;
   logic meas_pending = 1'b0;
   logic [SAMPLE_W-1:0] min_val = MIN_INIT;
   logic [1:0] class_fifo [0:QUEUE_DEPTH-1];
   int fifo_rd = 0;
   int fifo_wr = 0;
   int fifo_cnt = 0;
   logic [1:0] tray_pos = 2'd0;
   logic part_busy = 1'b0;
   logic exit_toggle = 1'b0;
   logic [TALLY_W-1:0] bin_count [0:3] = '{default: '0};

   rsp_item_type sort_results_due [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int acted_items = 0;
   bit idle_on = 1'b1;

   function automatic logic [1:0] grade_reflectivity(input logic [SAMPLE_W-1:0] v);
      if (v > black_thr) return CLASS_BLACK;
      if (v > white_thr) return CLASS_WHITE;
      if (v > steel_thr) return CLASS_STEEL;
      return CLASS_ALUMINUM;
   endfunction

   task automatic predict_sort(input req_item_type it, output rsp_item_type res);
      logic [1:0] diff;
      res = '0;
      acted_items++;
      case (it.req_type)
         REQ_OPTICAL: begin
            if (!win_open) begin
               win_open = 1'b1;
               meas_pending = 1'b1;
               min_val = MIN_INIT;
            end else begin
               win_open = 1'b0;
            end
         end
         REQ_SAMPLE: begin
            if (win_open || meas_pending) begin
               if (it.sample < min_val) min_val = it.sample;
               if (!win_open) begin
                  meas_pending = 1'b0;
                  res.part_class = grade_reflectivity(min_val);
                  if (fifo_cnt >= QUEUE_DEPTH) begin
                     res.queue_overflow = 1'b1;
                  end else begin
                     class_fifo[fifo_wr] = res.part_class;
                     fifo_wr = (fifo_wr + 1) % QUEUE_DEPTH;
                     fifo_cnt++;
                     res.part_enqueued = 1'b1;
                  end
               end
            end else begin
               acted_items--;
            end
         end
         REQ_EXIT: begin
            if (!exit_toggle) begin
               exit_toggle = 1'b1;
            end else begin
               exit_toggle = 1'b0;
               if (bin_count[tray_pos] < TALLY_MAX) bin_count[tray_pos]++;
               res.bin_tally = bin_count[tray_pos];
               part_busy = 1'b0;
            end
         end
         default: begin
            acted_items--;
         end
      endcase
      if (!part_busy && fifo_cnt > 0) begin
         res.target_bin = class_fifo[fifo_rd];
         fifo_rd = (fifo_rd + 1) % QUEUE_DEPTH;
         fifo_cnt--;
         part_busy = 1'b1;
         res.move_valid = 1'b1;
         diff = res.target_bin - tray_pos;
         case (diff)
            TURN_QUARTER: begin
               res.move_dir = 1'b1;
               res.move_steps = quarter_cnt;
            end
            TURN_HALF: begin
               res.move_dir = 1'b1;
               res.move_steps = half_cnt;
            end
            TURN_BACK: begin
               res.move_steps = quarter_cnt;
            end
            default: ;
         endcase
         tray_pos = res.target_bin;
      end
      res.queue_level = LEVEL_W'(fifo_cnt);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("ERROR at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (sort_results_due.size() == 0) begin
            report_mismatch("transaction result with none outstanding", 1, 0);
         end else begin
            want = sort_results_due.pop_front();
            check_field("move_valid", 32'(rsp_data.move_valid), 32'(want.move_valid));
            check_field("move_dir", 32'(rsp_data.move_dir), 32'(want.move_dir));
            check_field("move_steps", 32'(rsp_data.move_steps), 32'(want.move_steps));
            check_field("target_bin", 32'(rsp_data.target_bin), 32'(want.target_bin));
            check_field("part_enqueued", 32'(rsp_data.part_enqueued),
                        32'(want.part_enqueued));
            check_field("part_class", 32'(rsp_data.part_class), 32'(want.part_class));
            check_field("queue_overflow", 32'(rsp_data.queue_overflow),
                        32'(want.queue_overflow));
            check_field("queue_level", 32'(rsp_data.queue_level), 32'(want.queue_level));
            check_field("bin_tally", 32'(rsp_data.bin_tally), 32'(want.bin_tally));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] kind, input logic [SAMPLE_W-1:0] value);
      req_item_type it;
      rsp_item_type res;
      int gap;
      it.req_type = kind;
      it.sample = value;
      @(negedge clock);
      start <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy !== 1'b0);
      predict_sort(it, res);
      sort_results_due.push_back(res);
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      start <= 1'b0;
      while (sort_results_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_BLACK: black_thr = value;
         CSR_WHITE: white_thr = value;
         CSR_STEEL: steel_thr = value;
         CSR_QUARTER: quarter_cnt = value[STEP_W-1:0];
         CSR_HALF: half_cnt = value[STEP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all_csrs(input logic [CSR_W-1:0] black, input logic [CSR_W-1:0] white,
                                 input logic [CSR_W-1:0] steel, input logic [CSR_W-1:0] quarter,
                                 input logic [CSR_W-1:0] half);
      write_csr(CSR_BLACK, black);
      write_csr(CSR_WHITE, white);
      write_csr(CSR_STEEL, steel);
      write_csr(CSR_QUARTER, quarter);
      write_csr(CSR_HALF, half);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return black_thr + SAMPLE_W'($urandom_range(0, 1));
      if (sel == 1) return white_thr + SAMPLE_W'($urandom_range(0, 1));
      if (sel == 2) return steel_thr + SAMPLE_W'($urandom_range(0, 1));
      return SAMPLE_W'($urandom_range(0, 1023));
   endfunction

   // A part whose minimum is the first sample after the window closes.
   task automatic send_part(input logic [SAMPLE_W-1:0] lowest);
      send_item(REQ_OPTICAL, SAMPLE_W'($urandom_range(0, 1023)));
      send_item(REQ_OPTICAL, SAMPLE_W'($urandom_range(0, 1023)));
      send_item(REQ_SAMPLE, lowest);
   endtask

   task automatic send_exit_pair();
      send_item(REQ_EXIT, SAMPLE_W'($urandom_range(0, 1023)));
      send_item(REQ_EXIT, SAMPLE_W'($urandom_range(0, 1023)));
   endtask

   task automatic test_directed_cases();
      send_item(REQ_SAMPLE, 10'd1023);
      send_item(REQ_UNUSED, 10'd0);
      send_exit_pair();
      send_item(REQ_OPTICAL, 10'd0);
      send_item(REQ_SAMPLE, 10'd1023);
      send_item(REQ_SAMPLE, 10'd975);
      send_item(REQ_OPTICAL, 10'd1023);
      send_item(REQ_SAMPLE, 10'd1023);
      send_part(10'd851);
      send_exit_pair();
      send_part(10'd381);
      send_exit_pair();
      send_part(10'd380);
      send_exit_pair();
      send_part(10'd1023);
      send_exit_pair();
   endtask

   task automatic test_config_extremes();
      wait_all_results();
      write_all_csrs(10'd0, 10'd0, 10'd0, 10'd255, 10'd0);
      send_part(10'd0);
      send_exit_pair();
      send_part(10'd1);
      send_exit_pair();
      send_part(10'd2);
      send_exit_pair();
      wait_all_results();
      write_all_csrs(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
      send_part(10'd1023);
      send_exit_pair();
      send_part(10'd0);
      send_exit_pair();
      wait_all_results();
      for (int i = CSR_HALF + 1; i < (1 << CSR_IDX_W); i++)
         write_csr(CSR_IDX_W'(i), CSR_W'($urandom_range(0, 1023)));
      send_part(10'd512);
      send_exit_pair();
      send_part(10'd200);
      send_exit_pair();
   endtask

   task automatic test_bin_saturation();
      repeat (260) send_exit_pair();
   endtask

   task automatic test_queue_overflow();
      repeat (20) send_part(pick_sample());
   endtask

   task automatic test_random_traffic(input int count);
      int goal;
      int pick;
      goal = acted_items + count;
      while (acted_items < goal) begin
         if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_item(REQ_OPTICAL, SAMPLE_W'($urandom_range(0, 1023)));
            repeat ($urandom_range(0, 3)) send_item(REQ_SAMPLE, pick_sample());
            send_item(REQ_OPTICAL, SAMPLE_W'($urandom_range(0, 1023)));
            send_item(REQ_SAMPLE, pick_sample());
            repeat ($urandom_range(0, 1)) send_item(REQ_SAMPLE, pick_sample());
         end else if (pick < 87) begin
            send_exit_pair();
         end else begin
            send_item(2'($urandom_range(0, 3)), SAMPLE_W'($urandom_range(0, 1023)));
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic test_random_phases();
      logic [CSR_W-1:0] steel;
      logic [CSR_W-1:0] white;
      wait_all_results();
      write_all_csrs(BLACK_RESET, WHITE_RESET, STEEL_RESET, CSR_W'(QUARTER_RESET),
                     CSR_W'(HALF_RESET));
      test_random_traffic(130);
      repeat (2) begin
         wait_all_results();
         steel = CSR_W'($urandom_range(0, 340));
         white = CSR_W'($urandom_range(steel, 680));
         write_all_csrs(CSR_W'($urandom_range(white, 1023)), white, steel,
                        CSR_W'($urandom_range(0, 1023)), CSR_W'($urandom_range(0, 1023)));
         test_random_traffic(130);
      end
      wait_all_results();
      write_all_csrs(CSR_W'($urandom_range(0, 1023)), CSR_W'($urandom_range(0, 1023)),
                     CSR_W'($urandom_range(0, 1023)), CSR_W'($urandom_range(0, 1023)),
                     CSR_W'($urandom_range(0, 1023)));
      test_random_traffic(130);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_config_extremes();
      test_bin_saturation();
      test_queue_overflow();
      test_random_phases();
      wait_all_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/mss_pkg.sv
sv/mss_ctrl.sv
sv/mss_datapath.sv
sv/material_sort_sequencer.sv
tb/tb.sv
